// File: sv/sle_pkg.sv
package sle_pkg;

   localparam int DEPTH_DEFAULT      = 128;
   localparam int DATA_WIDTH_DEFAULT = 32;
   localparam int OP_WIDTH           = 3;
   localparam int POS_WIDTH          = 8;
   localparam int VALUE_WIDTH        = 32;

   localparam logic [OP_WIDTH-1:0] OP_GET     = 3'd0;
   localparam logic [OP_WIDTH-1:0] OP_LOCATE  = 3'd1;
   localparam logic [OP_WIDTH-1:0] OP_INSERT  = 3'd2;
   localparam logic [OP_WIDTH-1:0] OP_DELETE  = 3'd3;
   localparam logic [OP_WIDTH-1:0] OP_REVERSE = 3'd4;

   typedef struct packed {
      logic [OP_WIDTH-1:0]           operation;
      logic [POS_WIDTH-1:0]          position;
      logic signed [VALUE_WIDTH-1:0] value;
   } req_type;

   typedef struct packed {
      logic                          ok;
      logic signed [VALUE_WIDTH-1:0] data_out;
      logic [POS_WIDTH-1:0]          found_position;
      logic [POS_WIDTH-1:0]          list_length;
      logic                          list_empty;
   } rsp_type;

   // shift: every cell loads its neighbor; dir 0 moves words toward the high
   // end, dir 1 toward the low end
   typedef struct packed {
      logic shift;
      logic dir;
   } chain_ctl_type;

endpackage

// File: sv/sle_cell.sv
module sle_cell #(
   parameter int DATA_WIDTH = sle_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                      clock,
   input  sle_pkg::chain_ctl_type    ctl,
   input  logic [DATA_WIDTH-1:0]     from_lo,
   input  logic [DATA_WIDTH-1:0]     from_hi,
   output logic [DATA_WIDTH-1:0]     word_out
);

   logic [DATA_WIDTH-1:0] word_ff;
   logic [DATA_WIDTH-1:0] word_in;

   assign word_in  = ctl.dir ? from_hi : from_lo;
   assign word_out = word_ff;

   always_ff @(posedge clock) begin
      if (ctl.shift) begin
         word_ff <= word_in;
      end
   end

endmodule

// File: sv/sle_chain.sv
module sle_chain #(
   parameter int DEPTH      = sle_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = sle_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                      clock,
   input  sle_pkg::chain_ctl_type    ctl,
   input  logic [DATA_WIDTH-1:0]     feed,
   output logic [DATA_WIDTH-1:0]     out_word,
   output logic [DATA_WIDTH-1:0]     next_word
);

   logic [DATA_WIDTH-1:0] cell_q [DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] lo_src;
      logic [DATA_WIDTH-1:0] hi_src;

      if (i == 0) begin : g_lo_end
         assign lo_src = feed;
      end else begin : g_lo_mid
         assign lo_src = cell_q[i-1];
      end

      if (i == DEPTH-1) begin : g_hi_end
         assign hi_src = feed;
      end else begin : g_hi_mid
         assign hi_src = cell_q[i+1];
      end

      sle_cell #(
         .DATA_WIDTH(DATA_WIDTH)
      ) u_cell (
         .clock   (clock),
         .ctl     (ctl),
         .from_lo (lo_src),
         .from_hi (hi_src),
         .word_out(cell_q[i])
      );
   end

   // the word leaving the chain, and the one right behind it
   assign out_word  = ctl.dir ? cell_q[0] : cell_q[DEPTH-1];
   assign next_word = ctl.dir ? cell_q[1] : cell_q[DEPTH-2];

endmodule

// File: sv/sequential_list_engine.sv
// Channel  Direction  Handshake              Payload
// req      in         req_valid / req_ready  req_item (sle_pkg::req_type)
// rsp      out        rsp_valid / rsp_ready  rsp_item (sle_pkg::rsp_type)
//
// Get, locate, insert and delete rotate the whole cell ring once, then post the
// result. Reverse rotates the ring by the list length and then flips its
// direction. A failed item or a reverse of an empty list skips the rotation
// and goes straight to posting its result.
// One item is in work at a time; a new item is taken while the result waits.
// Reset empties the list; cell contents are not cleared.
// A stalled rsp holds the finished item in the work state until rsp frees.
module sequential_list_engine #(
   parameter int DEPTH      = sle_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = sle_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sle_pkg::req_type req_item,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sle_pkg::rsp_type rsp_item
);

   localparam int CW   = $clog2(DEPTH + 1);
   localparam int PW   = sle_pkg::POS_WIDTH;
   localparam int VW   = sle_pkg::VALUE_WIDTH;
   localparam int CMPW = ((CW > PW) ? CW : PW) + 1;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_FIN  = 2'd2;

   logic [1:0]                    state_ff, state_in;
   logic [sle_pkg::OP_WIDTH-1:0]  op_ff, op_in;
   logic [PW-1:0]                 pos_ff, pos_in;
   logic [DATA_WIDTH-1:0]         word_ff, word_in;
   logic [DATA_WIDTH-1:0]         hold_ff, hold_in;
   logic [DATA_WIDTH-1:0]         data_ff, data_in;
   logic [CW-1:0]                 k_ff, k_in;
   logic [CW-1:0]                 found_ff, found_in;
   logic                          hit_ff, hit_in;
   logic                          ok_ff, ok_in;
   logic [CW-1:0]                 count_ff, count_in;
   logic                          orient_ff, orient_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   sle_pkg::rsp_type              rsp_ff, rsp_in;

   sle_pkg::chain_ctl_type        ctl;
   logic [DATA_WIDTH-1:0]         feed;
   logic [DATA_WIDTH-1:0]         out_word;
   logic [DATA_WIDTH-1:0]         next_word;

   logic [DATA_WIDTH-1:0]         req_word;
   logic signed [VW-1:0]          data_ext;
   logic [CMPW-1:0]               req_pos_x, cnt_x, k_x, pos_m1_x;
   logic                          req_fire, rsp_free;
   logic                          rd_ok, ins_ok;

   // value to stored width and back
   if (DATA_WIDTH >= VW) begin : g_wide
      assign req_word = {{(DATA_WIDTH-VW+1){req_item.value[VW-1]}},
                         req_item.value[VW-2:0]};
      assign data_ext = data_ff[VW-1:0];
   end else begin : g_narrow
      assign req_word = req_item.value[DATA_WIDTH-1:0];
      assign data_ext = {{(VW-DATA_WIDTH){data_ff[DATA_WIDTH-1]}}, data_ff};
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   assign req_pos_x = CMPW'(req_item.position);
   assign cnt_x     = CMPW'(count_ff);
   assign k_x       = CMPW'(k_ff);
   assign pos_m1_x  = CMPW'(pos_ff) - CMPW'(1);

   assign rd_ok  = (req_pos_x != '0) && (req_pos_x <= cnt_x);
   assign ins_ok = (cnt_x < CMPW'(DEPTH)) && (req_pos_x != '0)
                   && (req_pos_x <= cnt_x + CMPW'(1));

   assign ctl.shift = (state_ff == ST_RUN);
   assign ctl.dir   = orient_ff;

   sle_chain #(
      .DEPTH     (DEPTH),
      .DATA_WIDTH(DATA_WIDTH)
   ) u_chain (
      .clock    (clock),
      .ctl      (ctl),
      .feed     (feed),
      .out_word (out_word),
      .next_word(next_word)
   );

   // ring feed: splice in the new word for insert, skip one for delete
   always_comb begin
      feed = out_word;
      case (op_ff)
         sle_pkg::OP_INSERT: begin
            if (k_x == pos_m1_x) begin
               feed = word_ff;
            end else if (k_x > pos_m1_x) begin
               feed = hold_ff;
            end
         end
         sle_pkg::OP_DELETE: begin
            if (k_x >= pos_m1_x) begin
               feed = next_word;
            end
         end
         default: begin
            feed = out_word;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      pos_in       = pos_ff;
      word_in      = word_ff;
      hold_in      = hold_ff;
      data_in      = data_ff;
      k_in         = k_ff;
      found_in     = found_ff;
      hit_in       = hit_ff;
      ok_in        = ok_ff;
      count_in     = count_ff;
      orient_in    = orient_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               op_in    = req_item.operation;
               pos_in   = req_item.position;
               word_in  = req_word;
               data_in  = '0;
               found_in = '0;
               hit_in   = 1'b0;
               k_in     = '0;
               ok_in    = 1'b0;
               state_in = ST_FIN;
               case (req_item.operation)
                  sle_pkg::OP_GET, sle_pkg::OP_DELETE: begin
                     ok_in = rd_ok;
                     if (rd_ok) begin
                        state_in = ST_RUN;
                     end
                  end
                  sle_pkg::OP_LOCATE: begin
                     state_in = ST_RUN;
                  end
                  sle_pkg::OP_INSERT: begin
                     ok_in = ins_ok;
                     if (ins_ok) begin
                        state_in = ST_RUN;
                     end
                  end
                  sle_pkg::OP_REVERSE: begin
                     // rotate count steps, then flip direction
                     ok_in = 1'b1;
                     k_in  = CW'(DEPTH) - count_ff;
                     if (count_ff != '0) begin
                        state_in = ST_RUN;
                     end
                  end
                  default: begin
                     ok_in = 1'b0;
                  end
               endcase
            end
         end
         ST_RUN: begin
            hold_in = out_word;
            k_in    = k_ff + CW'(1);
            if ((op_ff == sle_pkg::OP_GET || op_ff == sle_pkg::OP_DELETE)
                && k_x == pos_m1_x) begin
               data_in = out_word;
            end
            if (op_ff == sle_pkg::OP_LOCATE && !hit_ff && k_x < cnt_x
                && out_word == word_ff) begin
               hit_in   = 1'b1;
               ok_in    = 1'b1;
               found_in = k_ff + CW'(1);
            end
            if (k_ff == CW'(DEPTH - 1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (rsp_free) begin
               if (ok_ff && op_ff == sle_pkg::OP_INSERT) begin
                  count_in = count_ff + CW'(1);
               end else if (ok_ff && op_ff == sle_pkg::OP_DELETE) begin
                  count_in = count_ff - CW'(1);
               end
               if (op_ff == sle_pkg::OP_REVERSE) begin
                  orient_in = !orient_ff;
               end
               rsp_in.ok             = ok_ff;
               rsp_in.data_out       = data_ext;
               rsp_in.found_position = PW'(found_ff);
               rsp_in.list_length    = PW'(count_in);
               rsp_in.list_empty     = (count_in == '0);
               rsp_valid_in          = 1'b1;
               state_in              = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         orient_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         orient_ff    <= orient_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      pos_ff   <= pos_in;
      word_ff  <= word_in;
      hold_ff  <= hold_in;
      data_ff  <= data_in;
      k_ff     <= k_in;
      found_ff <= found_in;
      hit_ff   <= hit_in;
      ok_ff    <= ok_in;
      rsp_ff   <= rsp_in;
   end

endmodule
